// ===== rtl/gphb_pkg.sv =====
// Shared types, codes and reset values for the geo point heatmap binner.
// No dependencies; the front, back, top and testbench files import this package.
`timescale 1ns / 1ps

package gphb_pkg;

    localparam int MAP_SIDE_DEFAULT = 1024;

    localparam int WORD_W    = 32;
    localparam int COORD_W   = 10;
    localparam int COUNT_W   = 8;
    localparam int TOTAL_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_LAT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_LON  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PPD         = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LIMIT = 2'd3;

    localparam logic [WORD_W-1:0]  RST_ORIGIN_LAT  = 32'd682840325;
    localparam logic [WORD_W-1:0]  RST_ORIGIN_LON  = 32'd3052697784;
    localparam logic [WORD_W-1:0]  RST_PPD         = 32'd516007756;
    localparam logic [COUNT_W-1:0] RST_COUNT_LIMIT = 8'd1;

    localparam logic [STATUS_W-1:0] ST_PLOTTED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_READ      = 2'd3;

    typedef enum logic [1:0] {
        CMD_PLOT,
        CMD_OUTSIDE,
        CMD_READ
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic               hit;
        logic [COORD_W-1:0] out_row;
        logic [COORD_W-1:0] out_col;
    } cmd_t;

endpackage

// ===== rtl/gphb_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module gphb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// ===== rtl/gphb_queue.sv =====
// Two-entry command queue between the front and back parts of the binner.
// No package dependencies.
`timescale 1ns / 1ps

module gphb_queue #(
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              full,
    output logic              not_empty
);

    logic [DATA_W-1:0] entry_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue pop while empty");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("queue count lost a transfer");

endmodule

// ===== rtl/gphb_front.sv =====
// Front part: accepts requests, converts float coordinates to map indices
// with one shared 32x32 multiplier, and queues commands. Uses gphb_pkg.
`timescale 1ns / 1ps

module gphb_front #(
    parameter int MAP_SIDE = gphb_pkg::MAP_SIDE_DEFAULT,
    parameter int ADDR_W   = $clog2(MAP_SIDE * MAP_SIDE)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             req_type,
    input  logic [gphb_pkg::WORD_W-1:0]      latitude_word,
    input  logic [gphb_pkg::WORD_W-1:0]      longitude_word,
    input  logic [gphb_pkg::COORD_W-1:0]     read_row,
    input  logic [gphb_pkg::COORD_W-1:0]     read_col,
    input  logic                             clear_done,
    input  logic signed [gphb_pkg::WORD_W-1:0] origin_latitude,
    input  logic signed [gphb_pkg::WORD_W-1:0] origin_longitude,
    input  logic [gphb_pkg::WORD_W-1:0]      pixels_per_degree,
    input  logic                             q_full,
    output logic                             q_push,
    output gphb_pkg::cmd_t                   q_cmd,
    output logic [ADDR_W-1:0]                q_addr
);

    import gphb_pkg::*;

    localparam int IDX_W = $clog2(MAP_SIDE);

    typedef enum logic [7:0] {
        F_IDLE    = 8'b0000_0001,
        F_CONV    = 8'b0000_0010,
        F_DIFF    = 8'b0000_0100,
        F_ABS     = 8'b0000_1000,
        F_MUL_LAT = 8'b0001_0000,
        F_MUL_LON = 8'b0010_0000,
        F_RND_LON = 8'b0100_0000,
        F_PUSH    = 8'b1000_0000
    } fstate_t;

    fstate_t state_reg;
    fstate_t state_next;

    logic                in_accept;
    logic                req_reg;
    logic [WORD_W-1:0]   lat_w_reg;
    logic [WORD_W-1:0]   lon_w_reg;
    logic [COORD_W-1:0]  rrow_reg;
    logic [COORD_W-1:0]  rcol_reg;

    logic [WORD_W-1:0]   q_lat_reg;
    logic [WORD_W-1:0]   q_lon_reg;
    logic                fin_lat_reg;
    logic                fin_lon_reg;
    logic                sgn_lat_reg;
    logic                sgn_lon_reg;

    logic signed [WORD_W:0] d_lat_reg;
    logic signed [WORD_W:0] d_lon_reg;
    logic signed [WORD_W:0] d_lat_next;
    logic signed [WORD_W:0] d_lon_next;
    logic signed [WORD_W:0] v_lat;
    logic signed [WORD_W:0] v_lon;

    logic [WORD_W-1:0]   mag_lat_reg;
    logic [WORD_W-1:0]   mag_lon_reg;
    logic                neg_lat_reg;
    logic                neg_lon_reg;

    logic [WORD_W-1:0]   mul_a;
    logic [63:0]         prod_reg;

    logic                rnd_inc;
    logic [24:0]         rnd_ip;
    logic                rnd_neg;
    logic                rnd_ok;

    logic [IDX_W-1:0]    row_reg;
    logic [IDX_W-1:0]    col_reg;
    logic                row_ok_reg;
    logic                col_ok_reg;

    logic                plot_ok;
    logic                read_hit;
    logic [IDX_W-1:0]    row_sel;
    logic [IDX_W-1:0]    col_sel;
    logic [ADDR_W-1:0]   addr_calc;

    // Float bits to {finite and below 128, Q8.24 magnitude}.
    function automatic logic [WORD_W:0] float_to_fixed(input logic [WORD_W-1:0] w);
        logic [7:0]        e;
        logic [WORD_W-1:0] sig;
        logic [WORD_W-1:0] q;
        logic [WORD_W-1:0] low_mask;
        logic [4:0]        k;
        logic              rbit;
        logic              sticky;
        logic              ok;
        e        = w[30:23];
        sig      = {8'd0, 1'b1, w[22:0]};
        ok       = (e < 8'd134);
        q        = '0;
        low_mask = '0;
        k        = '0;
        rbit     = 1'b0;
        sticky   = 1'b0;
        if (e == 8'd0)
        begin
            q = '0;
        end
        else if (e >= 8'd126)
        begin
            q = sig << (e - 8'd126);
        end
        else if (e >= 8'd102)
        begin
            k        = 5'(8'd126 - e);
            q        = sig >> k;
            rbit     = sig[k - 5'd1];
            low_mask = (32'd1 << (k - 5'd1)) - 32'd1;
            sticky   = |(sig & low_mask);
            q        = q + {31'd0, rbit & (sticky | q[0])};
        end
        return {ok, q};
    endfunction

    assign in_stall  = !((state_reg == F_IDLE) && clear_done);
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        v_lat = sgn_lat_reg ? -$signed({1'b0, q_lat_reg}) : $signed({1'b0, q_lat_reg});
        v_lon = sgn_lon_reg ? -$signed({1'b0, q_lon_reg}) : $signed({1'b0, q_lon_reg});
        d_lat_next = v_lat - $signed({origin_latitude[WORD_W-1], origin_latitude});
        d_lon_next = v_lon - $signed({origin_longitude[WORD_W-1], origin_longitude});
    end

    assign mul_a = (state_reg == F_MUL_LAT) ? mag_lat_reg : mag_lon_reg;

    // Round the Q.40 product to nearest, ties to even.
    assign rnd_inc = prod_reg[39] & ((|prod_reg[38:0]) | prod_reg[40]);
    assign rnd_ip  = {1'b0, prod_reg[63:40]} + 25'(rnd_inc);
    assign rnd_neg = (state_reg == F_MUL_LON) ? neg_lat_reg : neg_lon_reg;
    assign rnd_ok  = !(rnd_neg && (rnd_ip != '0)) && (rnd_ip < 25'(MAP_SIDE));

    assign plot_ok  = row_ok_reg && col_ok_reg;
    assign read_hit = (32'(rrow_reg) < 32'(MAP_SIDE)) && (32'(rcol_reg) < 32'(MAP_SIDE));
    assign row_sel  = req_reg ? IDX_W'(rrow_reg) : row_reg;
    assign col_sel  = req_reg ? IDX_W'(rcol_reg) : col_reg;
    assign addr_calc = ADDR_W'(row_sel) * ADDR_W'(MAP_SIDE) + ADDR_W'(col_sel);

    always_comb
    begin
        q_cmd = '0;
        if (req_reg)
        begin
            q_cmd.kind    = CMD_READ;
            q_cmd.hit     = read_hit;
            q_cmd.out_row = rrow_reg;
            q_cmd.out_col = rcol_reg;
        end
        else if (plot_ok)
        begin
            q_cmd.kind    = CMD_PLOT;
            q_cmd.hit     = 1'b1;
            q_cmd.out_row = COORD_W'(row_reg);
            q_cmd.out_col = COORD_W'(col_reg);
        end
        else
        begin
            q_cmd.kind = CMD_OUTSIDE;
        end
        q_addr = q_cmd.hit ? addr_calc : '0;
    end

    assign q_push = (state_reg == F_PUSH) && !q_full;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = req_type ? F_PUSH : F_CONV;
                end
            end
            F_CONV:    state_next = F_DIFF;
            F_DIFF:    state_next = F_ABS;
            F_ABS:     state_next = F_MUL_LAT;
            F_MUL_LAT: state_next = F_MUL_LON;
            F_MUL_LON: state_next = F_RND_LON;
            F_RND_LON: state_next = F_PUSH;
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:   state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_reg   <= req_type;
            lat_w_reg <= latitude_word;
            lon_w_reg <= longitude_word;
            rrow_reg  <= read_row;
            rcol_reg  <= read_col;
        end
        if (state_reg == F_CONV)
        begin
            {fin_lat_reg, q_lat_reg} <= float_to_fixed(lat_w_reg);
            {fin_lon_reg, q_lon_reg} <= float_to_fixed(lon_w_reg);
            sgn_lat_reg <= lat_w_reg[WORD_W-1];
            sgn_lon_reg <= lon_w_reg[WORD_W-1];
        end
        if (state_reg == F_DIFF)
        begin
            d_lat_reg <= d_lat_next;
            d_lon_reg <= d_lon_next;
        end
        if (state_reg == F_ABS)
        begin
            mag_lat_reg <= d_lat_reg[WORD_W] ? WORD_W'(-d_lat_reg) : d_lat_reg[WORD_W-1:0];
            mag_lon_reg <= d_lon_reg[WORD_W] ? WORD_W'(-d_lon_reg) : d_lon_reg[WORD_W-1:0];
            neg_lat_reg <= d_lat_reg[WORD_W];
            neg_lon_reg <= d_lon_reg[WORD_W];
        end
        if ((state_reg == F_MUL_LAT) || (state_reg == F_MUL_LON))
        begin
            prod_reg <= 64'(mul_a) * 64'(pixels_per_degree);
        end
        if (state_reg == F_MUL_LON)
        begin
            row_reg    <= IDX_W'(rnd_ip);
            row_ok_reg <= rnd_ok && fin_lat_reg;
        end
        if (state_reg == F_RND_LON)
        begin
            col_reg    <= IDX_W'(rnd_ip);
            col_ok_reg <= rnd_ok && fin_lon_reg;
        end
    end

endmodule

// ===== rtl/gphb_back.sv =====
// Back part: clears the cell store after reset, then carries out queued
// plot, outside and read commands on it and keeps the running totals. Uses gphb_pkg, gphb_ram.
`timescale 1ns / 1ps

module gphb_back #(
    parameter int MAP_SIDE = gphb_pkg::MAP_SIDE_DEFAULT,
    parameter int ADDR_W   = $clog2(MAP_SIDE * MAP_SIDE)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [gphb_pkg::COUNT_W-1:0]  count_limit,
    input  logic                          q_valid,
    input  gphb_pkg::cmd_t                q_cmd,
    input  logic [ADDR_W-1:0]             q_addr,
    output logic                          q_pop,
    output logic                          clear_done,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [gphb_pkg::STATUS_W-1:0] status,
    output logic [gphb_pkg::COORD_W-1:0]  pixel_row,
    output logic [gphb_pkg::COORD_W-1:0]  pixel_col,
    output logic [gphb_pkg::COUNT_W-1:0]  cell_count,
    output logic [gphb_pkg::TOTAL_W-1:0]  outside_total,
    output logic [gphb_pkg::TOTAL_W-1:0]  saturated_total
);

    import gphb_pkg::*;

    localparam int DEPTH = MAP_SIDE * MAP_SIDE;

    typedef enum logic [2:0] {
        B_CLEAR = 3'b001,
        B_IDLE  = 3'b010,
        B_LOOK  = 3'b100
    } bstate_t;

    bstate_t state_reg;
    bstate_t state_next;

    logic [ADDR_W-1:0]   clr_reg;
    logic [ADDR_W-1:0]   clr_next;
    cmd_t                cur_cmd_reg;
    logic [ADDR_W-1:0]   cur_addr_reg;

    logic                ram_we;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_addr;
    logic [COUNT_W-1:0]  ram_wdata;
    logic [COUNT_W-1:0]  ram_rdata;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic                load_out;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [COORD_W-1:0]  row_reg;
    logic [COORD_W-1:0]  col_reg;
    logic [COUNT_W-1:0]  cnt_reg;
    logic [COUNT_W-1:0]  cnt_next;

    logic [TOTAL_W-1:0]  outside_cnt_reg;
    logic [TOTAL_W-1:0]  outside_cnt_next;
    logic [TOTAL_W-1:0]  sat_cnt_reg;
    logic [TOTAL_W-1:0]  sat_cnt_next;

    gphb_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (DEPTH)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign clear_done      = (state_reg != B_CLEAR);
    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign pixel_row       = row_reg;
    assign pixel_col       = col_reg;
    assign cell_count      = cnt_reg;
    assign outside_total   = outside_cnt_reg;
    assign saturated_total = sat_cnt_reg;

    always_comb
    begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        q_pop            = 1'b0;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        ram_addr         = q_addr;
        ram_wdata        = '0;
        load_out         = 1'b0;
        status_next      = ST_READ;
        cnt_next         = '0;
        outside_cnt_next = outside_cnt_reg;
        sat_cnt_next     = sat_cnt_reg;
        out_valid_next   = out_valid_reg && out_stall;
        case (state_reg)
            B_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (q_valid && (!out_valid_reg || !out_stall))
                begin
                    q_pop      = 1'b1;
                    ram_re     = 1'b1;
                    state_next = B_LOOK;
                end
            end
            B_LOOK:
            begin
                ram_addr       = cur_addr_reg;
                load_out       = 1'b1;
                out_valid_next = 1'b1;
                state_next     = B_IDLE;
                case (cur_cmd_reg.kind)
                    CMD_PLOT:
                    begin
                        if (ram_rdata < count_limit)
                        begin
                            ram_we      = 1'b1;
                            ram_wdata   = ram_rdata + 1'b1;
                            status_next = ST_PLOTTED;
                            cnt_next    = ram_rdata + 1'b1;
                        end
                        else
                        begin
                            status_next = ST_SATURATED;
                            cnt_next    = ram_rdata;
                            if (sat_cnt_reg != '1)
                            begin
                                sat_cnt_next = sat_cnt_reg + 1'b1;
                            end
                        end
                    end
                    CMD_OUTSIDE:
                    begin
                        status_next = ST_OUTSIDE;
                        if (outside_cnt_reg != '1)
                        begin
                            outside_cnt_next = outside_cnt_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                        status_next = ST_READ;
                        cnt_next    = cur_cmd_reg.hit ? ram_rdata : '0;
                    end
                endcase
            end
            default: state_next = B_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= B_CLEAR;
            clr_reg         <= '0;
            out_valid_reg   <= 1'b0;
            outside_cnt_reg <= '0;
            sat_cnt_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_reg         <= clr_next;
            out_valid_reg   <= out_valid_next;
            outside_cnt_reg <= outside_cnt_next;
            sat_cnt_reg     <= sat_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_cmd_reg  <= q_cmd;
            cur_addr_reg <= q_addr;
        end
        if (load_out)
        begin
            status_reg <= status_next;
            row_reg    <= cur_cmd_reg.out_row;
            col_reg    <= cur_cmd_reg.out_col;
            cnt_reg    <= cnt_next;
        end
    end

    a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == B_IDLE) && (!out_valid_reg || !out_stall))
        else $error("command taken while result register busy");

    a_result_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == B_LOOK))
        else $error("result shown without a cell lookup");

    a_quiet_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CLEAR) |-> (!out_valid_reg && !q_pop))
        else $error("activity during clearing pass");

    a_write_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && (state_reg == B_LOOK)) |->
            ((cur_cmd_reg.kind == CMD_PLOT) && (ram_rdata < count_limit)))
        else $error("cell written at or above limit");

endmodule

// ===== rtl/geo_point_heatmap_binner.sv =====
// Geo point heatmap binner: a square histogram of latitude/longitude points.
// A plot point passes the front sequencer in steps (float conversion,
// origin offset, magnitude, then both coordinates through one shared 32x32
// multiplier and a rounding step); a cell read goes straight to the queue.
// The back part handles each command as a registered cell read, then a write
// when a plot counts; the front takes a new request once the last is queued.
// After reset the cell store is cleared one entry a cycle, MAP_SIDE*MAP_SIDE
// entries (1048576 at the default side), with in_stall held high meanwhile;
// configuration writes are taken at all times. Uses gphb_pkg and submodules.
`timescale 1ns / 1ps

module geo_point_heatmap_binner #(
    parameter int MAP_SIDE = gphb_pkg::MAP_SIDE_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            req_type,
    input  logic [gphb_pkg::WORD_W-1:0]     latitude_word,
    input  logic [gphb_pkg::WORD_W-1:0]     longitude_word,
    input  logic [gphb_pkg::COORD_W-1:0]    read_row,
    input  logic [gphb_pkg::COORD_W-1:0]    read_col,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [gphb_pkg::STATUS_W-1:0]   status,
    output logic [gphb_pkg::COORD_W-1:0]    pixel_row,
    output logic [gphb_pkg::COORD_W-1:0]    pixel_col,
    output logic [gphb_pkg::COUNT_W-1:0]    cell_count,
    output logic [gphb_pkg::TOTAL_W-1:0]    outside_total,
    output logic [gphb_pkg::TOTAL_W-1:0]    saturated_total,
    input  logic                            cfg_we,
    input  logic [gphb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gphb_pkg::WORD_W-1:0]     cfg_data
);

    import gphb_pkg::*;

    localparam int ADDR_W = $clog2(MAP_SIDE * MAP_SIDE);
    localparam int QW     = $bits(cmd_t) + ADDR_W;

    logic signed [WORD_W-1:0] origin_lat_reg;
    logic signed [WORD_W-1:0] origin_lon_reg;
    logic [WORD_W-1:0]        ppd_reg;
    logic [COUNT_W-1:0]       limit_reg;

    logic              clear_done;
    logic              q_full;
    logic              q_not_empty;
    logic              q_push;
    logic              q_pop;
    cmd_t              push_cmd;
    logic [ADDR_W-1:0] push_addr;
    cmd_t              head_cmd;
    logic [ADDR_W-1:0] head_addr;
    logic [QW-1:0]     head_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_lat_reg <= RST_ORIGIN_LAT;
            origin_lon_reg <= RST_ORIGIN_LON;
            ppd_reg        <= RST_PPD;
            limit_reg      <= RST_COUNT_LIMIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ORIGIN_LAT:  origin_lat_reg <= cfg_data;
                CFG_ORIGIN_LON:  origin_lon_reg <= cfg_data;
                CFG_PPD:         ppd_reg        <= cfg_data;
                CFG_COUNT_LIMIT: limit_reg      <= cfg_data[COUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    gphb_front #(
        .MAP_SIDE (MAP_SIDE),
        .ADDR_W   (ADDR_W)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .req_type          (req_type),
        .latitude_word     (latitude_word),
        .longitude_word    (longitude_word),
        .read_row          (read_row),
        .read_col          (read_col),
        .clear_done        (clear_done),
        .origin_latitude   (origin_lat_reg),
        .origin_longitude  (origin_lon_reg),
        .pixels_per_degree (ppd_reg),
        .q_full            (q_full),
        .q_push            (q_push),
        .q_cmd             (push_cmd),
        .q_addr            (push_addr)
    );

    gphb_queue #(
        .DATA_W (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_cmd, push_addr}),
        .pop       (q_pop),
        .pop_data  (head_data),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    assign {head_cmd, head_addr} = head_data;

    gphb_back #(
        .MAP_SIDE (MAP_SIDE),
        .ADDR_W   (ADDR_W)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .count_limit     (limit_reg),
        .q_valid         (q_not_empty),
        .q_cmd           (head_cmd),
        .q_addr          (head_addr),
        .q_pop           (q_pop),
        .clear_done      (clear_done),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .pixel_row       (pixel_row),
        .pixel_col       (pixel_col),
        .cell_count      (cell_count),
        .outside_total   (outside_total),
        .saturated_total (saturated_total)
    );

endmodule

// ===== dv/tb_geo_point_heatmap_binner.sv =====
// Testbench for geo_point_heatmap_binner: drives plot and read requests with
// bursty traffic and a stalling receiver, predicts every result in place.
// Depends on gphb_pkg and the geo_point_heatmap_binner RTL.
`timescale 1ns / 1ps

module tb_geo_point_heatmap_binner;

    import gphb_pkg::*;

    localparam int MAP_SIDE = MAP_SIDE_DEFAULT;
    localparam int HOT_CELLS = 8;
    localparam int LONG_HOLD = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT = 4 * MAP_SIDE * MAP_SIDE + 1000000;

    localparam bit REQ_PLOT = 1'b0;
    localparam bit REQ_READ = 1'b1;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    typedef struct packed {
        bit                req_type;
        bit [WORD_W-1:0]   lat;
        bit [WORD_W-1:0]   lon;
        bit [COORD_W-1:0]  row;
        bit [COORD_W-1:0]  col;
    } heat_req_t;

    typedef struct packed {
        bit [STATUS_W-1:0] status;
        bit [COORD_W-1:0]  row;
        bit [COORD_W-1:0]  col;
        bit [COUNT_W-1:0]  count;
        bit [TOTAL_W-1:0]  outside;
        bit [TOTAL_W-1:0]  saturated;
    } bin_report_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  req_type = 1'b0;
    logic [WORD_W-1:0]     latitude_word = '0;
    logic [WORD_W-1:0]     longitude_word = '0;
    logic [COORD_W-1:0]    read_row = '0;
    logic [COORD_W-1:0]    read_col = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [COORD_W-1:0]    pixel_row;
    logic [COORD_W-1:0]    pixel_col;
    logic [COUNT_W-1:0]    cell_count;
    logic [TOTAL_W-1:0]    outside_total;
    logic [TOTAL_W-1:0]    saturated_total;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [WORD_W-1:0]     cfg_data = '0;

    bit [WORD_W-1:0]  org_lat = RST_ORIGIN_LAT;
    bit [WORD_W-1:0]  org_lon = RST_ORIGIN_LON;
    bit [WORD_W-1:0]  scale_ppd = RST_PPD;
    bit [COUNT_W-1:0] cap_count = RST_COUNT_LIMIT;

    bit [COUNT_W-1:0] cell_shadow [0:MAP_SIDE*MAP_SIDE-1];
    bit [TOTAL_W-1:0] outside_tally = '0;
    bit [TOTAL_W-1:0] saturated_tally = '0;

    heat_req_t   heat_requests[$];
    bin_report_t bin_reports[$];
    heat_req_t   current_req;
    bin_report_t want;

    int          reports_due = 0;
    int          mismatches = 0;
    int          hot_row [HOT_CELLS];
    int          hot_col [HOT_CELLS];
    int          burst_left;
    int          gap_left;
    bit          taken;
    int          long_holds = 0;
    int          holds_served;
    int          hold_left;
    int          mode_left;
    stall_mode_t stall_mode;
    int unsigned cycle_count = 0;

    geo_point_heatmap_binner u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .latitude_word   (latitude_word),
        .longitude_word  (longitude_word),
        .read_row        (read_row),
        .read_col        (read_col),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .pixel_row       (pixel_row),
        .pixel_col       (pixel_col),
        .cell_count      (cell_count),
        .outside_total   (outside_total),
        .saturated_total (saturated_total),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit float_to_q824(input bit [31:0] w, output longint q);
        bit [7:0]  e;
        bit [63:0] sig;
        bit [63:0] mag;
        bit [63:0] rem;
        bit [63:0] half;
        int        k;
        e = w[30:23];
        q = 0;
        if (e == 8'hFF || e >= 8'd134)
            return 1'b0;
        mag = '0;
        if (e != 8'd0)
        begin
            sig = {40'd0, 1'b1, w[22:0]};
            if (e >= 8'd126)
                mag = sig << (e - 8'd126);
            else
            begin
                k = 126 - int'(e);
                if (k <= 30)
                begin
                    rem = sig & ((64'd1 << k) - 64'd1);
                    half = 64'd1 << (k - 1);
                    mag = sig >> k;
                    if (rem > half || (rem == half && mag[0]))
                        mag = mag + 64'd1;
                end
            end
        end
        q = w[31] ? -longint'(mag) : longint'(mag);
        return 1'b1;
    endfunction

    function automatic bit map_index(input bit [31:0] w, input bit [31:0] origin,
                                     output bit [COORD_W-1:0] idx);
        longint    v;
        longint    d;
        bit [63:0] mag;
        bit [63:0] prod;
        bit [63:0] ip;
        bit [63:0] rem;
        idx = '0;
        if (!float_to_q824(w, v))
            return 1'b0;
        d = v - longint'(signed'(origin));
        mag = (d < 0) ? 64'(-d) : 64'(d);
        prod = mag * 64'(scale_ppd);
        ip = prod >> 40;
        rem = {24'd0, prod[39:0]};
        if (rem > (64'd1 << 39) || (rem == (64'd1 << 39) && ip[0]))
            ip = ip + 64'd1;
        if (d < 0 && ip != 64'd0)
            return 1'b0;
        if (ip >= 64'(MAP_SIDE))
            return 1'b0;
        idx = ip[COORD_W-1:0];
        return 1'b1;
    endfunction

    function automatic bin_report_t bin_update(heat_req_t r);
        bin_report_t      rep;
        bit [COORD_W-1:0] ri;
        bit [COORD_W-1:0] ci;
        bit               ok_r;
        bit               ok_c;
        int               a;
        rep = '0;
        if (r.req_type == REQ_READ)
        begin
            rep.status = ST_READ;
            rep.row = r.row;
            rep.col = r.col;
            if (int'(r.row) < MAP_SIDE && int'(r.col) < MAP_SIDE)
                rep.count = cell_shadow[int'(r.row) * MAP_SIDE + int'(r.col)];
        end
        else
        begin
            ok_r = map_index(r.lat, org_lat, ri);
            ok_c = map_index(r.lon, org_lon, ci);
            if (!(ok_r && ok_c))
            begin
                rep.status = ST_OUTSIDE;
                if (outside_tally != '1)
                    outside_tally++;
            end
            else
            begin
                a = int'(ri) * MAP_SIDE + int'(ci);
                rep.row = ri;
                rep.col = ci;
                if (cell_shadow[a] < cap_count)
                begin
                    cell_shadow[a]++;
                    rep.status = ST_PLOTTED;
                end
                else
                begin
                    rep.status = ST_SATURATED;
                    if (saturated_tally != '1)
                        saturated_tally++;
                end
                rep.count = cell_shadow[a];
            end
        end
        rep.outside = outside_tally;
        rep.saturated = saturated_tally;
        return rep;
    endfunction

    function automatic bit [31:0] real_to_single(real x);
        bit [63:0] d;
        int        e;
        d = $realtobits(x);
        e = int'(d[62:52]) - 1023 + 127;
        if (d[62:0] == 63'd0 || e <= 0)
            return {d[63], 31'd0};
        if (e >= 255)
            return {d[63], 8'hFF, 23'd0};
        return {d[63], e[7:0], d[51:29]};
    endfunction

    function automatic real coord_deg(bit [31:0] origin, real pix);
        if (scale_ppd == '0)
            return real'(int'($urandom_range(0, 254000)) - 127000) / 1000.0;
        return real'(signed'(origin)) / 16777216.0 + pix * 65536.0 / real'(scale_ppd);
    endfunction

    function automatic real jitter();
        return (real'($urandom_range(0, 900)) - 450.0) / 1000.0;
    endfunction

    function automatic bit [31:0] noise_word();
        bit [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 7))
            0: w[30:23] = 8'hFF;
            1: w[30:23] = 8'd0;
            2: w[30:23] = 8'd134;
            3: w[30:23] = 8'd133;
            4: w[30:23] = 8'd126;
            5: w[30:23] = 8'($urandom_range(96, 125));
            default: ;
        endcase
        return w;
    endfunction

    function automatic heat_req_t make_raw(bit [31:0] lat, bit [31:0] lon);
        heat_req_t r;
        r.req_type = REQ_PLOT;
        r.lat = lat;
        r.lon = lon;
        r.row = COORD_W'($urandom);
        r.col = COORD_W'($urandom);
        return r;
    endfunction

    function automatic heat_req_t make_plot(real prow, real pcol);
        return make_raw(real_to_single(coord_deg(org_lat, prow)),
                        real_to_single(coord_deg(org_lon, pcol)));
    endfunction

    function automatic heat_req_t make_read(int row, int col);
        heat_req_t r;
        r.req_type = REQ_READ;
        r.lat = $urandom;
        r.lon = $urandom;
        r.row = COORD_W'(row);
        r.col = COORD_W'(col);
        return r;
    endfunction

    function automatic heat_req_t random_request();
        int  sel;
        int  k;
        int  rim;
        real border;
        real other;
        sel = $urandom_range(0, 99);
        k = $urandom_range(0, HOT_CELLS - 1);
        if (sel < 30)
            return make_plot(hot_row[k] + jitter(), hot_col[k] + jitter());
        if (sel < 55)
            return make_plot(real'($urandom_range(0, MAP_SIDE - 1)) + jitter(),
                             real'($urandom_range(0, MAP_SIDE - 1)) + jitter());
        if (sel < 65)
        begin
            rim = $urandom_range(0, 5);
            border = real'((rim < 3) ? rim - 2 : MAP_SIDE + rim - 4) + jitter();
            other = real'($urandom_range(0, MAP_SIDE - 1));
            if ($urandom_range(0, 1) == 0)
                return make_plot(border, other);
            return make_plot(other, border);
        end
        if (sel < 72)
            return make_read(hot_row[k], hot_col[k]);
        if (sel < 80)
            return make_read($urandom_range(0, MAP_SIDE - 1), $urandom_range(0, MAP_SIDE - 1));
        if (sel < 90)
            return make_raw(noise_word(), noise_word());
        if (sel < 95)
            return make_raw(noise_word(), real_to_single(coord_deg(org_lon, hot_col[k])));
        return make_raw(real_to_single(coord_deg(org_lat, hot_row[k])), noise_word());
    endfunction

    task automatic queue_request(heat_req_t r);
        heat_requests.push_back(r);
        reports_due++;
    endtask

    task automatic wait_drained();
        while (reports_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [31:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_ORIGIN_LAT:  org_lat = data;
            CFG_ORIGIN_LON:  org_lon = data;
            CFG_PPD:         scale_ppd = data;
            CFG_COUNT_LIMIT: cap_count = data[COUNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
        begin
            queue_request(random_request());
            if (i % 100 == 99)
                wait_drained();
        end
        wait_drained();
    endtask

    // Driver: bursts of transfers separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            taken = in_valid && !in_stall;
            if (taken)
                bin_reports.push_back(bin_update(current_req));
            if (taken || !in_valid)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (heat_requests.size() != 0)
                begin
                    current_req = heat_requests.pop_front();
                    in_valid <= 1'b1;
                    req_type <= current_req.req_type;
                    latitude_word <= current_req.lat;
                    longitude_word <= current_req.lon;
                    read_row <= current_req.row;
                    read_col <= current_req.col;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern of its own, plus long hold-offs on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            holds_served = 0;
            hold_left = 0;
            mode_left = 0;
            stall_mode = STALL_NONE;
        end
        else
        begin
            if (long_holds != holds_served)
            begin
                holds_served = long_holds;
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            else
                mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                case (stall_mode)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                    default:     out_stall <= mode_left[2];
                endcase
        end
    end

    function automatic void check_field(string name, longint unsigned exp_v,
                                        longint unsigned got_v);
        if (exp_v != got_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            mismatches++;
        end
    endfunction

    // Monitor: compare each result transfer with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (bin_reports.size() == 0)
            begin
                $error("result transfer with no prediction pending");
                mismatches++;
            end
            else
            begin
                want = bin_reports.pop_front();
                check_field("status", want.status, status);
                check_field("pixel_row", want.row, pixel_row);
                check_field("pixel_col", want.col, pixel_col);
                check_field("cell_count", want.count, cell_count);
                check_field("outside_total", want.outside, outside_total);
                check_field("saturated_total", want.saturated, saturated_total);
                reports_due--;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_geo_point_heatmap_binner NOT OK");
            $finish;
        end
    end

    initial
    begin : main
        bit [31:0] lon_ok;
        for (int i = 0; i < HOT_CELLS; i++)
        begin
            hot_row[i] = $urandom_range(0, MAP_SIDE - 1);
            hot_col[i] = $urandom_range(0, MAP_SIDE - 1);
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        lon_ok = real_to_single(coord_deg(org_lon, 100.0));
        queue_request(make_raw(32'h0000_0000, 32'h0000_0000));
        queue_request(make_raw(32'h7FC0_0000, lon_ok));
        queue_request(make_raw(32'h7F80_0000, lon_ok));
        queue_request(make_raw(real_to_single(coord_deg(org_lat, 5.0)), 32'hFF80_0000));
        queue_request(make_raw(32'h4300_0000, lon_ok));
        queue_request(make_raw(32'hC300_0000, 32'hC300_0000));
        queue_request(make_raw(32'h42FF_FFFF, lon_ok));
        queue_request(make_raw(32'h0000_0001, 32'h8000_0001));
        queue_request(make_raw(32'h7F7F_FFFF, 32'hFFFF_FFFF));
        queue_request(make_plot(0.0, 0.0));
        queue_request(make_plot(0.0, 0.0));
        queue_request(make_plot(MAP_SIDE - 1, MAP_SIDE - 1));
        queue_request(make_plot(MAP_SIDE, 5.0));
        queue_request(make_plot(-1.0, 7.0));
        queue_request(make_plot(9.0, MAP_SIDE));
        queue_request(make_plot(-0.4, 3.0));
        queue_request(make_plot(3.0, -0.4));
        queue_request(make_read(0, 0));
        queue_request(make_read(MAP_SIDE - 1, MAP_SIDE - 1));
        queue_request(make_read(0, MAP_SIDE - 1));
        queue_request(make_plot(hot_row[0], hot_col[0]));
        queue_request(make_plot(hot_row[0], hot_col[0]));
        queue_request(make_read(hot_row[0], hot_col[0]));
        queue_request(make_read($urandom_range(0, MAP_SIDE - 1),
                                $urandom_range(0, MAP_SIDE - 1)));
        wait_drained();

        write_reg(CFG_COUNT_LIMIT, 32'd3);
        end_writes();
        long_holds++;
        run_random(300);

        write_reg(CFG_ORIGIN_LAT, 32'h0000_0000);
        write_reg(CFG_ORIGIN_LON, 32'h0000_0000);
        write_reg(CFG_PPD, 32'hFFFF_FFFF);
        write_reg(CFG_COUNT_LIMIT, 32'd255);
        end_writes();
        run_random(250);

        write_reg(CFG_ORIGIN_LAT, 32'h8000_0000);
        write_reg(CFG_ORIGIN_LON, 32'h7FFF_FFFF);
        write_reg(CFG_PPD, 32'h0000_0000);
        write_reg(CFG_COUNT_LIMIT, 32'd2);
        end_writes();
        run_random(150);

        write_reg(CFG_ORIGIN_LAT, 32'(int'($urandom) >>> 1));
        write_reg(CFG_ORIGIN_LON, 32'(int'($urandom) >>> 1));
        write_reg(CFG_PPD, $urandom_range(32'd6553600, 32'd3932160000));
        write_reg(CFG_COUNT_LIMIT, $urandom_range(1, 6));
        end_writes();
        long_holds++;
        run_random(300);

        write_reg(CFG_ORIGIN_LAT, RST_ORIGIN_LAT);
        write_reg(CFG_ORIGIN_LON, RST_ORIGIN_LON);
        write_reg(CFG_PPD, RST_PPD);
        write_reg(CFG_COUNT_LIMIT, 32'd255);
        end_writes();
        for (int i = 0; i < 280; i++)
            queue_request(make_plot(hot_row[0], hot_col[0]));
        queue_request(make_read(hot_row[0], hot_col[0]));
        wait_drained();
        run_random(100);

        if (mismatches == 0 && bin_reports.size() == 0)
            $display("tb_geo_point_heatmap_binner OK");
        else
            $display("tb_geo_point_heatmap_binner NOT OK");
        $finish;
    end

endmodule
